// ===== sv/pmi_pkg.sv =====
// Shared types, constants and the arctangent table of the pose midpoint integrator.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package pmi_pkg;

   // Default number of CORDIC iterations; the table below supports up to 23.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int STEP_W           = 5;

   // Angles in units of 1/65536 degree.
   localparam int FULL_CIRCLE    = 23592960;
   localparam int HALF_CIRCLE    = 11796480;
   localparam int QUARTER_CIRCLE = 5898240;

   // Gain-compensated 1.0 in Q1.30.
   localparam int CORDIC_GAIN = 652032874;

   // Configuration register map.
   localparam int          CSR_ADDR_W    = 3;
   localparam logic        TIME_STEP_IDX = 1'b0;
   localparam logic [15:0] TS_RESET      = 16'd655;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              mul_p;
      logic              mul_d;
      logic              save_dist;
      logic              wrap_start_mid;
      logic              wrap_start_full;
      logic              wrap_step;
      logic              save_mid;
      logic              save_full;
      logic              cordic_start;
      logic              cordic_step;
      logic              mul_x;
      logic              mul_y;
      logic              commit;
      logic [STEP_W-1:0] step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic zero_step;
   } sts_type;

   // atan(2^-i) in 1/65536 degree, rounded to nearest.
   function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29334;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/pmi_ctrl.sv =====
// Sequencing state machine of the pose midpoint integrator.
// Depends on pmi_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module pmi_ctrl
   import pmi_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_MUL_P     = 11'b00000000010,
      S_MUL_D     = 11'b00000000100,
      S_WRAP_MID  = 11'b00000001000,
      S_FULL_INIT = 11'b00000010000,
      S_WRAP_FULL = 11'b00000100000,
      S_CORD_INIT = 11'b00001000000,
      S_CORDIC    = 11'b00010000000,
      S_MUL_X     = 11'b00100000000,
      S_MUL_Y     = 11'b01000000000,
      S_COMMIT    = 11'b10000000000
   } state_type;

   localparam logic [STEP_W-1:0] WRAP_LAST   = STEP_W'(4);
   localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state, step counter and commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.step = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = accept;
            if (accept) begin
               state_in = sts.zero_step ? S_COMMIT : S_MUL_P;
            end
         end
         S_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.mul_d          = 1'b1;
            cmd.wrap_start_mid = 1'b1;
            cnt_in             = '0;
            state_in           = S_WRAP_MID;
         end
         S_WRAP_MID: begin
            cmd.wrap_step = 1'b1;
            cmd.save_dist = (cnt_ff == '0);
            if (cnt_ff == WRAP_LAST) begin
               cnt_in   = '0;
               state_in = S_FULL_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FULL_INIT: begin
            cmd.save_mid        = 1'b1;
            cmd.wrap_start_full = 1'b1;
            state_in            = S_WRAP_FULL;
         end
         S_WRAP_FULL: begin
            cmd.wrap_step = 1'b1;
            if (cnt_ff == WRAP_LAST) begin
               cnt_in   = '0;
               state_in = S_CORD_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CORD_INIT: begin
            cmd.save_full    = 1'b1;
            cmd.cordic_start = 1'b1;
            state_in         = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               cnt_in   = '0;
               state_in = S_MUL_X;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = S_MUL_Y;
         end
         S_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = sts.out_free;
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/pmi_dp.sv =====
// Datapath of the pose midpoint integrator: shared multiplier, angle wrap unit,
// iterative CORDIC and the pose registers. Depends on pmi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmi_dp
   import pmi_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  wire         [15:0] time_step,
   input  wire  signed [23:0] req_linear_speed,
   input  wire  signed [27:0] req_angular_rate,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [24:0] rsp_heading
);

   localparam logic signed [30:0] FULL1 = 31'(FULL_CIRCLE);
   localparam logic signed [30:0] FULL2 = 31'(2 * FULL_CIRCLE);
   localparam logic signed [30:0] FULL4 = 31'(4 * FULL_CIRCLE);
   localparam logic signed [30:0] FULL8 = 31'(8 * FULL_CIRCLE);
   localparam logic signed [30:0] HALF1 = 31'(HALF_CIRCLE);
   localparam logic signed [25:0] QUART = 26'(QUARTER_CIRCLE);
   localparam logic signed [25:0] HALFZ = 26'(HALF_CIRCLE);

   // Request and pose registers.
   logic signed [23:0] speed_ff;
   logic signed [27:0] rate_ff;
   logic               skip_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [24:0] head_ff;
   logic               rsp_valid_ff;

   // Working registers.
   logic signed [63:0] prod_ff;
   logic signed [40:0] dist_ff;
   logic signed [30:0] full_ff;
   logic signed [30:0] acc_ff;
   logic signed [24:0] mid_ff;
   logic signed [24:0] hnew_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [25:0] cz_ff;
   logic               flip_ff;
   logic signed [27:0] dx_ff;

   logic signed [41:0] mul_a;
   logic signed [22:0] mul_b;
   logic signed [64:0] prod_w;
   logic signed [63:0] half_w, fullt_w, rnd_w;
   logic signed [30:0] wrap_thr, wrap_sub;
   logic signed [25:0] ang_w, z0_w, atan_w;
   logic signed [33:0] cneg_w, sneg_w, cs_w, ss_w, xs_w, ys_w;
   logic signed [22:0] c20_w, s20_w;
   logic signed [33:0] sum_x_w, sum_y_w;
   logic signed [22:0] ts_s;

   // Saturate a 34-bit sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign ts_s = $signed({7'b0, time_step});

   // Shared multiplier operand selection.
   always_comb begin
      if (cmd.mul_p) begin
         mul_a = 42'(rate_ff);
         mul_b = ts_s;
      end else if (cmd.mul_d) begin
         mul_a = 42'(speed_ff);
         mul_b = ts_s;
      end else if (cmd.mul_x) begin
         mul_a = 42'(dist_ff);
         mul_b = c20_w;
      end else begin
         mul_a = 42'(dist_ff);
         mul_b = s20_w;
      end
   end

   assign prod_w  = mul_a * mul_b;
   assign half_w  = (prod_ff + 64'sd65536) >>> 17;
   assign fullt_w = (prod_ff + 64'sd32768) >>> 16;
   assign rnd_w   = (prod_ff + 64'sh8_0000_0000) >>> 36;

   // Wrap unit: restoring reduction by 8, 4, 2 and 1 circles, then into [-180,180).
   always_comb begin
      case (cmd.step)
         5'd0: begin
            wrap_thr = FULL8;
            wrap_sub = FULL8;
         end
         5'd1: begin
            wrap_thr = FULL4;
            wrap_sub = FULL4;
         end
         5'd2: begin
            wrap_thr = FULL2;
            wrap_sub = FULL2;
         end
         5'd3: begin
            wrap_thr = FULL1;
            wrap_sub = FULL1;
         end
         default: begin
            wrap_thr = HALF1;
            wrap_sub = FULL1;
         end
      endcase
   end

   // Quadrant fold of the midpoint heading before the CORDIC.
   always_comb begin
      ang_w = 26'(mid_ff);
      if (ang_w > QUART) begin
         z0_w = ang_w - HALFZ;
      end else if (ang_w < -QUART) begin
         z0_w = ang_w + HALFZ;
      end else begin
         z0_w = ang_w;
      end
   end

   // One CORDIC rotation per cycle.
   assign xs_w   = cx_ff >>> cmd.step;
   assign ys_w   = cy_ff >>> cmd.step;
   assign atan_w = $signed({4'b0, atan_lut(cmd.step)});

   // Undo the fold and reduce cos and sin to Q1.20.
   assign cneg_w = flip_ff ? -cx_ff : cx_ff;
   assign sneg_w = flip_ff ? -cy_ff : cy_ff;
   assign cs_w   = cneg_w >>> 10;
   assign ss_w   = sneg_w >>> 10;
   assign c20_w  = cs_w[22:0];
   assign s20_w  = ss_w[22:0];

   assign sum_x_w = 34'(x_ff) + 34'(dx_ff);
   assign sum_y_w = 34'(y_ff) + 34'($signed(rnd_w[27:0]));

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         speed_ff <= req_linear_speed;
         rate_ff  <= req_angular_rate;
         skip_ff  <= (time_step == 16'd0);
      end
      if (cmd.mul_p || cmd.mul_d || cmd.mul_x || cmd.mul_y) begin
         prod_ff <= prod_w[63:0];
      end
      if (cmd.mul_d) begin
         full_ff <= fullt_w[30:0];
      end
      if (cmd.save_dist) begin
         dist_ff <= prod_ff[40:0];
      end
      if (cmd.wrap_start_mid) begin
         acc_ff <= 31'(head_ff) + half_w[30:0] + FULL8;
      end else if (cmd.wrap_start_full) begin
         acc_ff <= 31'(head_ff) + full_ff + FULL8;
      end else if (cmd.wrap_step && (acc_ff >= wrap_thr)) begin
         acc_ff <= acc_ff - wrap_sub;
      end
      if (cmd.save_mid) begin
         mid_ff <= acc_ff[24:0];
      end
      if (cmd.save_full) begin
         hnew_ff <= acc_ff[24:0];
      end
      if (cmd.cordic_start) begin
         cx_ff   <= 34'(CORDIC_GAIN);
         cy_ff   <= '0;
         cz_ff   <= z0_w;
         flip_ff <= (ang_w > QUART) || (ang_w < -QUART);
      end else if (cmd.cordic_step) begin
         if (!cz_ff[25]) begin
            cx_ff <= cx_ff - ys_w;
            cy_ff <= cy_ff + xs_w;
            cz_ff <= cz_ff - atan_w;
         end else begin
            cx_ff <= cx_ff + ys_w;
            cy_ff <= cy_ff - xs_w;
            cz_ff <= cz_ff + atan_w;
         end
      end
      if (cmd.mul_y) begin
         dx_ff <= rnd_w[27:0];
      end
   end

   // Pose and result handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            if (!skip_ff) begin
               x_ff    <= sat32(sum_x_w);
               y_ff    <= sat32(sum_y_w);
               head_ff <= hnew_ff;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.zero_step = (time_step == 16'd0);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = x_ff;
   assign rsp_pos_y   = y_ff;
   assign rsp_heading = head_ff;

endmodule
`default_nettype wire

// ===== sv/pose_midpoint_integrator_top.sv =====
// Top level of the pose midpoint integrator: configuration register, controller
// and datapath. Depends on pmi_pkg, pmi_ctrl and pmi_dp.
//
// Use: each request on the req_ channel carries body speed (Q8.16 m/s) and turn
// rate (1/65536 deg/s). The block advances its x, y and heading and returns the
// new pose as one response on the rsp_ channel. A request is taken when req_valid
// is high and req_stall low; a response is taken when rsp_valid is high and
// rsp_stall low. The time step register sits at byte address 0 of the APB port.
// A request with a non-zero time step passes through two products, the
// five-step angle wrap run twice, the one-rotation-per-cycle CORDIC and two
// more products; the commit waits while the previous response is stalled. The
// block then returns to idle, so it takes one request at a time.
// A zero time step goes straight to the commit and returns the unchanged pose.
// A finished pose waits in the output register while rsp_stall is high; the
// pose does not change and the next request may already be accepted meanwhile.
// Reset clears the pose to zero and loads a time step of 655 (about 10 ms).
`timescale 1ns / 1ps
`default_nettype none
module pose_midpoint_integrator_top
   import pmi_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  signed [23:0]   req_linear_speed,
   input  wire  signed [27:0]   req_angular_rate,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic signed [24:0]   rsp_heading,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [CSR_ADDR_W-1:0] paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [15:0] ts_ff;
   logic        csr_wr;
   cmd_type     cmd;
   sts_type     sts;

   // Configuration register.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == TIME_STEP_IDX) ? {16'd0, ts_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= TS_RESET;
      end else if (csr_wr && (paddr[2] == TIME_STEP_IDX)) begin
         ts_ff <= pwdata[15:0];
      end
   end

   // Controller.
   pmi_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   pmi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .time_step        (ts_ff),
      .req_linear_speed (req_linear_speed),
      .req_angular_rate (req_angular_rate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_heading      (rsp_heading)
   );

`ifndef SYNTHESIS
   // An accepted request keeps the input side stalled in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an accepted request");

   // The reported heading always lies in [-180,180) degrees.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_heading >= -HALF_CIRCLE) && (rsp_heading < HALF_CIRCLE)))
      else $error("heading outside the wrapped range");

   // A response only leaves once it has been taken.
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("response dropped while stalled");
`endif

endmodule
`default_nettype wire
